[rtl/irt_pkg.sv]
// Shared types and codes for the interval reservation table.
// No dependencies; irt_match and the top module refer to it by scoped name.
package irt_pkg;

  typedef enum logic [2:0] {
    CMD_ADD        = 3'd0,
    CMD_REMOVE     = 3'd1,
    CMD_SHIFT      = 3'd2,
    CMD_FREE       = 3'd3,
    CMD_FREE_EXCPT = 3'd4,
    CMD_LOOKUP     = 3'd5
  } cmd_t;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MOVE_RD,
    S_MOVE_WR,
    S_ADD_WR,
    S_SORT_RDI,
    S_SORT_LDI,
    S_SORT_RDJ,
    S_SORT_CMPJ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic id_eq;
    logic collide;
    logic holds;
  } match_t;

endpackage

[rtl/irt_if.sv]
// Valid/ready channel interfaces for command transfers and result transfers.
// Standalone; field widths are fixed by the command and result formats.
interface irt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] entry_id;
  logic [31:0] start_time;
  logic [31:0] end_time;
  logic [31:0] probe_time;

  modport source (output valid, command, entry_id, start_time, end_time, probe_time,
                  input ready);
  modport sink   (input valid, command, entry_id, start_time, end_time, probe_time,
                  output ready);
endinterface

interface irt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] assigned_id;
  logic        slot_free;
  logic        hit;
  logic [15:0] found_id;
  logic [31:0] found_start;
  logic [31:0] found_end;
  logic [4:0]  entry_count;

  modport source (output valid, status, assigned_id, slot_free, hit, found_id,
                  found_start, found_end, entry_count, input ready);
  modport sink   (input valid, status, assigned_id, slot_free, hit, found_id,
                  found_start, found_end, entry_count, output ready);
endinterface

[rtl/irt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module irt_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/irt_match.sv]
// Compares one stored entry against the request: id match, overlap, probe hit.
// Depends on irt_pkg for the result struct.
module irt_match #(
  parameter int TIME_BITS = 32
) (
  input  logic [15:0]          req_id,
  input  logic [TIME_BITS-1:0] req_start,
  input  logic [TIME_BITS-1:0] req_end,
  input  logic [TIME_BITS-1:0] req_probe,
  input  logic [15:0]          ent_id,
  input  logic [TIME_BITS-1:0] ent_start,
  input  logic [TIME_BITS-1:0] ent_end,
  output irt_pkg::match_t      result
);

  logic start_inside;
  logic end_inside;
  logic covers;

  // overlap: request start inside, request end inside, or request covers entry
  assign start_inside = (req_start >= ent_start) && (req_start < ent_end);
  assign end_inside   = (req_end > ent_start) && (req_end <= ent_end);
  assign covers       = (req_start <= ent_start) && (req_end >= ent_end);

  assign result.id_eq   = (req_id == ent_id);
  assign result.collide = start_inside || end_inside || covers;
  assign result.holds   = (req_probe >= ent_start) && (req_probe < ent_end);

endmodule

[rtl/interval_reservation_table_top.sv]
// Interval reservation table: command FSM around one entry RAM.
// Depends on irt_pkg, irt_if (irt_in_if, irt_out_if), irt_ram and irt_match.
//
//   channel  | dir | transfer moves
//   ---------+-----+------------------------------------------------------
//   in_ch    | in  | command, entry_id, start_time, end_time, probe_time
//   out_ch   | out | status, assigned_id, slot_free, hit, found_id,
//            |     | found_start, found_end, entry_count
//
// Flow: every table access is a RAM read state followed by a state that uses
// the data. A scan (remove search, shift, check free, lookup) visits entries
// in order; remove then moves each later entry down one place. Add writes the
// new entry, then runs the exchange sort through the single RAM read port.
// A full add or an unused command goes straight to the result.
// Reset: clears control, entry count and id counter; RAM contents are left
// as they are and only entries below the count are ever read.
// Stalls: one command is in work at a time; a new command transfer is taken
// while a finished result still waits in the output register.
module interval_reservation_table_top #(
  parameter int CAPACITY  = 16,
  parameter int TIME_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  irt_in_if.sink    in_ch,
  irt_out_if.source out_ch
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = 16 + 2 * TIME_BITS;

  // request registers
  irt_pkg::cmd_t        cmd_r,   cmd_nxt;
  logic [15:0]          id_r,    id_nxt;
  logic [TIME_BITS-1:0] st_r,    st_nxt;
  logic [TIME_BITS-1:0] en_r,    en_nxt;
  logic [TIME_BITS-1:0] pr_r,    pr_nxt;

  // table state
  logic [CW-1:0]        used_r,  used_nxt;
  logic [15:0]          idctr_r, idctr_nxt;

  // walk state
  irt_pkg::state_t      state_r, state_nxt;
  logic [CW-1:0]        k_r,     k_nxt;
  logic [CW-1:0]        j_r,     j_nxt;
  logic [EW-1:0]        cur_r,   cur_nxt;

  // result being built
  logic [1:0]           rstat_r, rstat_nxt;
  logic [15:0]          rasg_r,  rasg_nxt;
  logic                 rfree_r, rfree_nxt;
  logic                 rhit_r,  rhit_nxt;
  logic [15:0]          rfid_r,  rfid_nxt;
  logic [TIME_BITS-1:0] rfst_r,  rfst_nxt;
  logic [TIME_BITS-1:0] rfen_r,  rfen_nxt;

  // output register
  logic                 ovld_r,  ovld_nxt;
  logic [1:0]           ostat_r;
  logic [15:0]          oasg_r;
  logic                 ofree_r;
  logic                 ohit_r;
  logic [15:0]          ofid_r;
  logic [TIME_BITS-1:0] ofst_r;
  logic [TIME_BITS-1:0] ofen_r;
  logic [CW-1:0]        ocnt_r;

  logic                 in_xfer;
  logic                 out_load;

  // RAM port
  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [EW-1:0]        ram_wdata;
  logic                 ram_re;
  logic [IW-1:0]        ram_raddr;
  logic [EW-1:0]        ram_rdata;

  logic [15:0]          rd_id;
  logic [TIME_BITS-1:0] rd_start;
  logic [TIME_BITS-1:0] rd_end;
  logic [TIME_BITS-1:0] cur_start;
  irt_pkg::match_t      mt;

  logic [CW-1:0]        k_inc;
  logic [CW-1:0]        j_inc;
  logic                 is_check;

  assign rd_id     = ram_rdata[EW-1 -: 16];
  assign rd_start  = ram_rdata[2*TIME_BITS-1 -: TIME_BITS];
  assign rd_end    = ram_rdata[TIME_BITS-1:0];
  assign cur_start = cur_r[2*TIME_BITS-1 -: TIME_BITS];
  assign k_inc     = CW'(k_r + 1'b1);
  assign j_inc     = CW'(j_r + 1'b1);

  assign in_ch.ready = (state_r == irt_pkg::S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == irt_pkg::S_DONE) && (!ovld_r || out_ch.ready);
  assign is_check    = (in_ch.command == irt_pkg::CMD_FREE) ||
                       (in_ch.command == irt_pkg::CMD_FREE_EXCPT);

  irt_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  irt_match #(
    .TIME_BITS (TIME_BITS)
  ) u_match (
    .req_id    (id_r),
    .req_start (st_r),
    .req_end   (en_r),
    .req_probe (pr_r),
    .ent_id    (rd_id),
    .ent_start (rd_start),
    .ent_end   (rd_end),
    .result    (mt)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      irt_pkg::S_IDLE: begin
        if (in_xfer) begin
          unique case (irt_pkg::cmd_t'(in_ch.command))
            irt_pkg::CMD_ADD: begin
              state_nxt = (used_r == CW'(CAPACITY)) ? irt_pkg::S_DONE : irt_pkg::S_ADD_WR;
            end
            irt_pkg::CMD_REMOVE, irt_pkg::CMD_SHIFT, irt_pkg::CMD_FREE,
            irt_pkg::CMD_FREE_EXCPT, irt_pkg::CMD_LOOKUP: begin
              state_nxt = irt_pkg::S_SCAN_RD;
            end
            default: state_nxt = irt_pkg::S_DONE;
          endcase
        end
      end
      irt_pkg::S_SCAN_RD: begin
        state_nxt = (k_r == used_r) ? irt_pkg::S_DONE : irt_pkg::S_SCAN_CHK;
      end
      irt_pkg::S_SCAN_CHK: begin
        priority case (cmd_r)
          irt_pkg::CMD_REMOVE:
            state_nxt = mt.id_eq ? irt_pkg::S_MOVE_RD : irt_pkg::S_SCAN_RD;
          irt_pkg::CMD_SHIFT:
            state_nxt = mt.id_eq ? irt_pkg::S_DONE : irt_pkg::S_SCAN_RD;
          irt_pkg::CMD_FREE:
            state_nxt = mt.collide ? irt_pkg::S_DONE : irt_pkg::S_SCAN_RD;
          irt_pkg::CMD_FREE_EXCPT:
            state_nxt = (mt.collide && !mt.id_eq) ? irt_pkg::S_DONE : irt_pkg::S_SCAN_RD;
          irt_pkg::CMD_LOOKUP:
            state_nxt = mt.holds ? irt_pkg::S_DONE : irt_pkg::S_SCAN_RD;
          default: state_nxt = irt_pkg::S_DONE;
        endcase
      end
      irt_pkg::S_MOVE_RD: begin
        state_nxt = (k_inc == used_r) ? irt_pkg::S_DONE : irt_pkg::S_MOVE_WR;
      end
      irt_pkg::S_MOVE_WR:   state_nxt = irt_pkg::S_MOVE_RD;
      irt_pkg::S_ADD_WR:    state_nxt = irt_pkg::S_SORT_RDI;
      irt_pkg::S_SORT_RDI: begin
        state_nxt = (k_r == used_r) ? irt_pkg::S_DONE : irt_pkg::S_SORT_LDI;
      end
      irt_pkg::S_SORT_LDI:  state_nxt = irt_pkg::S_SORT_RDJ;
      irt_pkg::S_SORT_RDJ: begin
        state_nxt = (j_r == used_r) ? irt_pkg::S_SORT_RDI : irt_pkg::S_SORT_CMPJ;
      end
      irt_pkg::S_SORT_CMPJ: state_nxt = irt_pkg::S_SORT_RDJ;
      irt_pkg::S_DONE: begin
        if (out_load) begin
          state_nxt = irt_pkg::S_IDLE;
        end
      end
      default: state_nxt = irt_pkg::S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    cmd_nxt   = cmd_r;
    id_nxt    = id_r;
    st_nxt    = st_r;
    en_nxt    = en_r;
    pr_nxt    = pr_r;
    used_nxt  = used_r;
    idctr_nxt = idctr_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    cur_nxt   = cur_r;
    rstat_nxt = rstat_r;
    rasg_nxt  = rasg_r;
    rfree_nxt = rfree_r;
    rhit_nxt  = rhit_r;
    rfid_nxt  = rfid_r;
    rfst_nxt  = rfst_r;
    rfen_nxt  = rfen_r;
    ovld_nxt  = ovld_r && !out_ch.ready;
    ram_we    = 1'b0;
    ram_waddr = k_r[IW-1:0];
    ram_wdata = cur_r;
    ram_re    = 1'b0;
    ram_raddr = k_r[IW-1:0];

    unique case (state_r)
      irt_pkg::S_IDLE: begin
        if (in_xfer) begin
          // capture the request, mask times, preset the result to defaults
          cmd_nxt   = irt_pkg::cmd_t'(in_ch.command);
          id_nxt    = in_ch.entry_id;
          st_nxt    = TIME_BITS'(in_ch.start_time);
          en_nxt    = TIME_BITS'(in_ch.end_time);
          pr_nxt    = TIME_BITS'(in_ch.probe_time);
          k_nxt     = '0;
          rstat_nxt = irt_pkg::STATUS_OK;
          rasg_nxt  = '0;
          rfree_nxt = is_check;
          rhit_nxt  = 1'b0;
          rfid_nxt  = '0;
          rfst_nxt  = '0;
          rfen_nxt  = '0;
          if ((in_ch.command == irt_pkg::CMD_ADD) && (used_r == CW'(CAPACITY))) begin
            rstat_nxt = irt_pkg::STATUS_FULL;
          end
        end
      end
      irt_pkg::S_SCAN_RD: begin
        if (k_r == used_r) begin
          if ((cmd_r == irt_pkg::CMD_REMOVE) || (cmd_r == irt_pkg::CMD_SHIFT)) begin
            rstat_nxt = irt_pkg::STATUS_NOT_FOUND;
          end
        end else begin
          ram_re = 1'b1;
        end
      end
      irt_pkg::S_SCAN_CHK: begin
        k_nxt = k_inc;
        priority case (cmd_r)
          irt_pkg::CMD_REMOVE: begin
            if (mt.id_eq) begin
              k_nxt = k_r;  // hold at the hit; the move starts here
            end
          end
          irt_pkg::CMD_SHIFT: begin
            if (mt.id_eq) begin
              ram_we    = 1'b1;
              ram_wdata = {rd_id, st_r, en_r};
            end
          end
          irt_pkg::CMD_FREE: begin
            if (mt.collide) begin
              rfree_nxt = 1'b0;
            end
          end
          irt_pkg::CMD_FREE_EXCPT: begin
            if (mt.collide && !mt.id_eq) begin
              rfree_nxt = 1'b0;
            end
          end
          irt_pkg::CMD_LOOKUP: begin
            if (mt.holds) begin
              rhit_nxt = 1'b1;
              rfid_nxt = rd_id;
              rfst_nxt = rd_start;
              rfen_nxt = rd_end;
            end
          end
          default: k_nxt = k_r;
        endcase
      end
      irt_pkg::S_MOVE_RD: begin
        if (k_inc == used_r) begin
          used_nxt = CW'(used_r - 1'b1);
        end else begin
          ram_re    = 1'b1;
          ram_raddr = k_inc[IW-1:0];
        end
      end
      irt_pkg::S_MOVE_WR: begin
        // pull the next entry down one place
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        k_nxt     = k_inc;
      end
      irt_pkg::S_ADD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = used_r[IW-1:0];
        ram_wdata = {idctr_r, st_r, en_r};
        rasg_nxt  = idctr_r;
        idctr_nxt = idctr_r + 16'd1;
        used_nxt  = CW'(used_r + 1'b1);
        k_nxt     = '0;
      end
      irt_pkg::S_SORT_RDI: begin
        if (k_r != used_r) begin
          ram_re = 1'b1;
        end
      end
      irt_pkg::S_SORT_LDI: begin
        cur_nxt = ram_rdata;
        j_nxt   = k_inc;
      end
      irt_pkg::S_SORT_RDJ: begin
        if (j_r == used_r) begin
          // place the running minimum at position i, advance i
          ram_we = 1'b1;
          k_nxt  = k_inc;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = j_r[IW-1:0];
        end
      end
      irt_pkg::S_SORT_CMPJ: begin
        if (cur_start > rd_start) begin
          // swap: old entry i lands at j, entry j becomes the new entry i
          ram_we    = 1'b1;
          ram_waddr = j_r[IW-1:0];
          cur_nxt   = ram_rdata;
        end
        j_nxt = j_inc;
      end
      irt_pkg::S_DONE: begin
        if (out_load) begin
          ovld_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= irt_pkg::S_IDLE;
      used_r  <= '0;
      idctr_r <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      idctr_r <= idctr_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    id_r    <= id_nxt;
    st_r    <= st_nxt;
    en_r    <= en_nxt;
    pr_r    <= pr_nxt;
    k_r     <= k_nxt;
    j_r     <= j_nxt;
    cur_r   <= cur_nxt;
    rstat_r <= rstat_nxt;
    rasg_r  <= rasg_nxt;
    rfree_r <= rfree_nxt;
    rhit_r  <= rhit_nxt;
    rfid_r  <= rfid_nxt;
    rfst_r  <= rfst_nxt;
    rfen_r  <= rfen_nxt;
    if (out_load) begin
      ostat_r <= rstat_r;
      oasg_r  <= rasg_r;
      ofree_r <= rfree_r;
      ohit_r  <= rhit_r;
      ofid_r  <= rfid_r;
      ofst_r  <= rfst_r;
      ofen_r  <= rfen_r;
      ocnt_r  <= used_r;
    end
  end

  assign out_ch.valid       = ovld_r;
  assign out_ch.status      = ostat_r;
  assign out_ch.assigned_id = oasg_r;
  assign out_ch.slot_free   = ofree_r;
  assign out_ch.hit         = ohit_r;
  assign out_ch.found_id    = ofid_r;
  assign out_ch.found_start = 32'(ofst_r);
  assign out_ch.found_end   = 32'(ofen_r);
  assign out_ch.entry_count = 5'(ocnt_r);

endmodule

[verif/tb_irt_scoreboard.sv]
// Scoreboard for the interval reservation table: table predictor and result check.
// Depends on irt_pkg; used by tb_top.
`timescale 1ns / 100ps

class irt_scoreboard;
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] assigned_id;
    logic        slot_free;
    logic        hit;
    logic [15:0] found_id;
    logic [31:0] found_start;
    logic [31:0] found_end;
    logic [4:0]  entry_count;
  } result_t;

  logic [15:0] tab_id[16];
  logic [31:0] tab_start[16];
  logic [31:0] tab_end[16];
  int unsigned used;
  logic [15:0] next_id;
  result_t pending[$];
  int unsigned errors;
  int unsigned n_results;

  function new();
    used = 0;
    next_id = 0;
    errors = 0;
    n_results = 0;
  endfunction

  function int find_first(logic [15:0] id);
    for (int k = 0; k < used; k++)
      if (tab_id[k] == id) return k;
    return -1;
  endfunction

  function void swap_entries(int a, int b);
    logic [15:0] ti;
    logic [31:0] ts, te;
    ti = tab_id[a]; ts = tab_start[a]; te = tab_end[a];
    tab_id[a] = tab_id[b]; tab_start[a] = tab_start[b]; tab_end[a] = tab_end[b];
    tab_id[b] = ti; tab_start[b] = ts; tab_end[b] = te;
  endfunction

  // Work out the result of one command and queue it.
  function void note_command(logic [2:0] cmd, logic [15:0] id, logic [31:0] st,
                             logic [31:0] en, logic [31:0] pr);
    result_t r;
    int pos;
    logic [31:0] s, e;
    r = '0;
    case (cmd)
      irt_pkg::CMD_ADD: begin
        if (used >= 16) begin
          r.status = irt_pkg::STATUS_FULL;
        end else begin
          tab_id[used] = next_id; tab_start[used] = st; tab_end[used] = en;
          used++;
          r.assigned_id = next_id;
          next_id++;
          for (int i = 0; i < used; i++)
            for (int j = i; j < used; j++)
              if (tab_start[i] > tab_start[j]) swap_entries(i, j);
        end
      end
      irt_pkg::CMD_REMOVE: begin
        pos = find_first(id);
        if (pos < 0) begin
          r.status = irt_pkg::STATUS_NOT_FOUND;
        end else begin
          for (int k = pos; k + 1 < used; k++) begin
            tab_id[k] = tab_id[k+1]; tab_start[k] = tab_start[k+1];
            tab_end[k] = tab_end[k+1];
          end
          used--;
        end
      end
      irt_pkg::CMD_SHIFT: begin
        pos = find_first(id);
        if (pos < 0) begin
          r.status = irt_pkg::STATUS_NOT_FOUND;
        end else begin
          tab_start[pos] = st; tab_end[pos] = en;
        end
      end
      irt_pkg::CMD_FREE, irt_pkg::CMD_FREE_EXCPT: begin
        r.slot_free = 1'b1;
        for (int k = 0; k < used; k++) begin
          s = tab_start[k]; e = tab_end[k];
          if (!(cmd == irt_pkg::CMD_FREE_EXCPT && tab_id[k] == id) &&
              ((st >= s && st < e) || (en > s && en <= e) || (st <= s && en >= e))) begin
            r.slot_free = 1'b0;
            break;
          end
        end
      end
      irt_pkg::CMD_LOOKUP: begin
        for (int k = 0; k < used; k++) begin
          if (pr >= tab_start[k] && pr < tab_end[k]) begin
            r.hit = 1'b1; r.found_id = tab_id[k];
            r.found_start = tab_start[k]; r.found_end = tab_end[k];
            break;
          end
        end
      end
      default: ;
    endcase
    r.entry_count = used[4:0];
    pending = {pending, r};
  endfunction

  function void check_result(result_t act);
    result_t x;
    n_results++;
    if (pending.size() == 0) begin
      $error("result with nothing expected");
      errors++;
      return;
    end
    x = pending.pop_front();
    if (act.status !== x.status) begin
      $error("status exp %0d got %0d", x.status, act.status); errors++;
    end
    if (act.assigned_id !== x.assigned_id) begin
      $error("assigned_id exp %0d got %0d", x.assigned_id, act.assigned_id); errors++;
    end
    if (act.slot_free !== x.slot_free) begin
      $error("slot_free exp %0d got %0d", x.slot_free, act.slot_free); errors++;
    end
    if (act.hit !== x.hit) begin
      $error("hit exp %0d got %0d", x.hit, act.hit); errors++;
    end
    if (act.found_id !== x.found_id) begin
      $error("found_id exp %0d got %0d", x.found_id, act.found_id); errors++;
    end
    if (act.found_start !== x.found_start) begin
      $error("found_start exp %0h got %0h", x.found_start, act.found_start); errors++;
    end
    if (act.found_end !== x.found_end) begin
      $error("found_end exp %0h got %0h", x.found_end, act.found_end); errors++;
    end
    if (act.entry_count !== x.entry_count) begin
      $error("entry_count exp %0d got %0d", x.entry_count, act.entry_count); errors++;
    end
  endfunction
endclass

[verif/tb_top.sv]
// Testbench top for interval_reservation_table_top: directed and random command
// streams with random idling. Depends on irt_pkg, irt_if and tb_irt_scoreboard.
`timescale 1ns / 100ps

module tb_top;

  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  irt_in_if  in_ch();
  irt_out_if out_ch();

  interval_reservation_table_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  irt_scoreboard table_model = new();
  int unsigned send_idle_pct;   // chance of a gap before a command, percent
  int unsigned recv_stall_pct;  // chance of ready low in a cycle, percent
  int unsigned cycles;
  int unsigned n_sent;
  logic [15:0] recent_id;       // last id handed out, for hitting live entries

  // Drive ready at random; a stall percentage of zero keeps it high.
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every result transfer.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      table_model.check_result({out_ch.status, out_ch.assigned_id, out_ch.slot_free,
                                out_ch.hit, out_ch.found_id, out_ch.found_start,
                                out_ch.found_end, out_ch.entry_count});
      if (out_ch.status == irt_pkg::STATUS_OK && out_ch.assigned_id != 0)
        recent_id <= out_ch.assigned_id;
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("interval_reservation_table_top test failed");
      $finish;
    end
  end

  // Present one command and hold it until the transfer; note it at acceptance.
  // Drop valid only when a gap follows, so valid sees one assignment per edge.
  task automatic send_command(logic [2:0] cmd, logic [15:0] id, logic [31:0] st,
                              logic [31:0] en, logic [31:0] pr);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.entry_id <= id;
    in_ch.start_time <= st;
    in_ch.end_time <= en;
    in_ch.probe_time <= pr;
    do @(posedge clk); while (!in_ch.ready);
    table_model.note_command(cmd, id, st, en, pr);
    n_sent++;
  endtask

  // Random command, mostly well-formed: times in a small window so intervals
  // overlap, ids near ones actually handed out so remove and shift hit.
  task automatic send_random();
    logic [2:0] cmd;
    logic [15:0] id;
    logic [31:0] st, en, pr;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 30) cmd = irt_pkg::CMD_ADD;
    else if (sel < 45) cmd = irt_pkg::CMD_REMOVE;
    else if (sel < 55) cmd = irt_pkg::CMD_SHIFT;
    else if (sel < 68) cmd = irt_pkg::CMD_FREE;
    else if (sel < 80) cmd = irt_pkg::CMD_FREE_EXCPT;
    else if (sel < 97) cmd = irt_pkg::CMD_LOOKUP;
    else cmd = 3'($urandom_range(7));
    if ($urandom_range(9) < 8) begin
      st = $urandom_range(1000);
      en = st + $urandom_range(120);
      pr = $urandom_range(1100);
      id = recent_id - 16'($urandom_range(20));
    end else begin
      st = $urandom; en = $urandom; pr = $urandom; id = 16'($urandom);
    end
    send_command(cmd, id, st, en, pr);
  endtask

  // Let the queue drain so the next phase starts from a quiet block.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (table_model.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = '0;
    in_ch.entry_id = '0;
    in_ch.start_time = '0;
    in_ch.end_time = '0;
    in_ch.probe_time = '0;
    cycles = 0;
    n_sent = 0;
    recent_id = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-table ops, extremes, fill to full, full add, misses.
    send_command(irt_pkg::CMD_LOOKUP, 16'h0, 32'h0, 32'h0, 32'h0);
    send_command(irt_pkg::CMD_REMOVE, 16'hFFFF, 32'h0, 32'h0, 32'h0);
    send_command(irt_pkg::CMD_SHIFT, 16'h0, 32'h0, 32'h0, 32'h0);
    send_command(irt_pkg::CMD_FREE, 16'h0, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_command(irt_pkg::CMD_ADD, 16'hFFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(irt_pkg::CMD_ADD, 16'h0, 32'h0, 32'h10, 32'h0);
    send_command(irt_pkg::CMD_ADD, 16'h0, 32'h80, 32'h40, 32'h0); // inverted interval
    for (int k = 0; k < 14; k++)
      send_command(irt_pkg::CMD_ADD, 16'h0, 32'(1000 - k * 50), 32'(1030 - k * 50), 32'h0);
    send_command(irt_pkg::CMD_ADD, 16'h0, 32'h5, 32'h6, 32'h0);   // table full
    send_command(irt_pkg::CMD_LOOKUP, 16'h0, 32'h0, 32'h0, 32'hFFFF_FFF5);
    send_command(irt_pkg::CMD_FREE_EXCPT, 16'h1, 32'h8, 32'h9, 32'h0);
    send_command(irt_pkg::CMD_SHIFT, 16'h2, 32'h7FFF_FFFF, 32'h8000_0001, 32'h0);
    send_command(irt_pkg::CMD_REMOVE, 16'h0, 32'h0, 32'h0, 32'h0);
    send_command(3'd6, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(3'd7, 16'h0, 32'h0, 32'h0, 32'h0);
    recent_id = 16'd15;
    drain();

    // Random phases with different idling.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        3: begin send_idle_pct = 10; recv_stall_pct = 10; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      repeat (350) send_random();
      drain();
    end

    $display("Covered %0d commands and %0d checked results across five idling phases.",
             n_sent, table_model.n_results);
    if (table_model.errors == 0 && table_model.pending.size() == 0)
      $display("interval_reservation_table_top test passed");
    else
      $display("interval_reservation_table_top test failed");
    $finish;
  end
endmodule
